// ===== hdl/imadec_pkg.sv =====
package imadec_pkg;

    localparam int unsigned STEP_COUNT = 89;
    localparam logic [6:0]  IDX_MAX    = 7'd88;

    localparam logic       MODE_HEADER = 1'b0;
    localparam logic       MODE_DATA   = 1'b1;

    // Step sizes for step index 0 through 88
    localparam logic [14:0] STEP_TABLE [STEP_COUNT] = '{
        15'h0007, 15'h0008, 15'h0009, 15'h000a, 15'h000b, 15'h000c, 15'h000d, 15'h000e,
        15'h0010, 15'h0011, 15'h0013, 15'h0015, 15'h0017, 15'h0019, 15'h001c, 15'h001f,
        15'h0022, 15'h0025, 15'h0029, 15'h002d, 15'h0032, 15'h0037, 15'h003c, 15'h0042,
        15'h0049, 15'h0050, 15'h0058, 15'h0061, 15'h006b, 15'h0076, 15'h0082, 15'h008f,
        15'h009d, 15'h00ad, 15'h00be, 15'h00d1, 15'h00e6, 15'h00fd, 15'h0117, 15'h0133,
        15'h0151, 15'h0173, 15'h0198, 15'h01c1, 15'h01ee, 15'h0220, 15'h0256, 15'h0292,
        15'h02d4, 15'h031c, 15'h036c, 15'h03c3, 15'h0424, 15'h048e, 15'h0502, 15'h0583,
        15'h0610, 15'h06ab, 15'h0756, 15'h0812, 15'h08e0, 15'h09c3, 15'h0abd, 15'h0bd0,
        15'h0cff, 15'h0e4c, 15'h0fba, 15'h114c, 15'h1307, 15'h14ee, 15'h1706, 15'h1954,
        15'h1bdc, 15'h1ea5, 15'h21b6, 15'h2515, 15'h28ca, 15'h2cdf, 15'h315b, 15'h364b,
        15'h3bb9, 15'h41b2, 15'h4844, 15'h4f7e, 15'h5771, 15'h602f, 15'h69ce, 15'h7462,
        15'h7fff
    };

    typedef struct packed {
        logic        mode;
        logic [31:0] header_word;
        logic [3:0]  code;
        logic        loop_mark;
        logic        loop_back;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [6:0]         step_index_out;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [6:0]         idx;
        logic signed [15:0] loop_sample;
        logic [6:0]         loop_idx;
    } dec_state_t;

    function automatic logic [6:0] cap_index(input logic [6:0] i);
        cap_index = (i > IDX_MAX) ? IDX_MAX : i;
    endfunction

endpackage

// ===== hdl/imadec_core.sv =====
module imadec_core
    import imadec_pkg::*;
(
    input  in_item_t   item,
    input  dec_state_t state,
    output dec_state_t state_next
);

    localparam logic signed [17:0] SAT_POS = 18'sd32767;
    localparam logic signed [17:0] SAT_NEG = -18'sd32767;
    localparam logic signed [7:0]  IDX_TOP = 8'sd88;

    logic signed [15:0] loop_sample_new;
    logic [6:0]         loop_idx_new;
    logic signed [15:0] base_sample;
    logic [6:0]         base_idx;
    logic [14:0]        step;
    logic [16:0]        delta;
    logic signed [17:0] sum;
    logic signed [15:0] sample_new;
    logic signed [7:0]  idx_adj;
    logic signed [7:0]  idx_sum;
    logic [6:0]         idx_new;

    always_comb
    begin
        // Save the loop point first, then restore from it
        loop_sample_new = item.loop_mark ? state.sample : state.loop_sample;
        loop_idx_new    = item.loop_mark ? state.idx    : state.loop_idx;
        base_sample     = item.loop_back ? loop_sample_new : state.sample;
        base_idx        = cap_index(item.loop_back ? loop_idx_new : state.idx);

        step  = STEP_TABLE[base_idx];
        delta = 17'(step >> 3)
              + (item.code[0] ? 17'(step >> 2) : 17'd0)
              + (item.code[1] ? 17'(step >> 1) : 17'd0)
              + (item.code[2] ? 17'(step)      : 17'd0);

        if (item.code[3])
        begin
            sum = {{2{base_sample[15]}}, base_sample} - $signed({1'b0, delta});
            sample_new = (sum < SAT_NEG) ? SAT_NEG[15:0] : sum[15:0];
        end
        else
        begin
            sum = {{2{base_sample[15]}}, base_sample} + $signed({1'b0, delta});
            sample_new = (sum > SAT_POS) ? SAT_POS[15:0] : sum[15:0];
        end

        idx_adj = item.code[2] ? $signed({5'd0, item.code[1:0], 1'b0}) + 8'sd2 : -8'sd1;
        idx_sum = $signed({1'b0, base_idx}) + idx_adj;
        if (idx_sum < 8'sd0)
            idx_new = 7'd0;
        else if (idx_sum > IDX_TOP)
            idx_new = IDX_MAX;
        else
            idx_new = idx_sum[6:0];

        if (item.mode == MODE_HEADER)
        begin
            state_next.sample      = item.header_word[15:0];
            state_next.idx         = cap_index(item.header_word[22:16]);
            state_next.loop_sample = state.loop_sample;
            state_next.loop_idx    = state.loop_idx;
        end
        else
        begin
            state_next.sample      = sample_new;
            state_next.idx         = idx_new;
            state_next.loop_sample = loop_sample_new;
            state_next.loop_idx    = loop_idx_new;
        end
    end

endmodule

// ===== hdl/ima_adpcm_nibble_decoder.sv =====
// Channel   Handshake                  Payload        Carries
// item      item_valid / item_stall    item           header word or one ADPCM nibble
// result    result_valid / result_stall result        sample and step index after the item
//
// One transfer on item gives exactly one transfer on result, via the hold and result
// registers. A new item is taken every cycle while the result is not stalled; throughput
// is set by the single decode pass (table lookup, shift-add, saturate) between the two.
// Reset clears the predictor, step index and loop point to zero and empties both stages.
// A stalled result holds; one more item then waits in the hold register before item_stall.
module ima_adpcm_nibble_decoder
    import imadec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    in_item_t   hold_item_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    out_item_t  res_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       advance;

    imadec_core u_core (
        .item       (hold_item_reg),
        .state      (state_reg),
        .state_next (state_next)
    );

    // Advance the held item into the result register when that register is free
    // or being emptied this cycle.
    assign advance    = hold_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = hold_valid_reg && !advance;

    always_comb
    begin
        if (item_valid && !item_stall)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;

        // Hold a stalled result, otherwise take whatever advances
        res_valid_next = (res_valid_reg && result_stall) || advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            hold_item_reg <= item;
        if (advance)
        begin
            res_reg.sample_out     <= state_next.sample;
            res_reg.step_index_out <= state_next.idx;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTH
    a_take_fills_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> hold_valid_reg)
        else $error("accepted item not held");

    a_hold_reaches_result: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !(res_valid_reg && result_stall)) |=> res_valid_reg)
        else $error("held item did not reach the result register");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.idx <= IDX_MAX) && (state_reg.loop_idx <= IDX_MAX))
        else $error("step index out of range");

    a_result_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.step_index_out <= IDX_MAX))
        else $error("result step index out of range");
`endif

endmodule
